// ----- rtl/sha256_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // Queue entry passed from the byte front end to the compression back end.
  // Each entry carries one whole 512-bit block.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_req_t;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam int unsigned LenOffset = 56;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sha256_message_hasher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-wide SHA-256 with padding; eight digest words per message.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                    | tuser / tlast
//  s_axis  | in  | data_byte[7:0]           | tuser: has_byte, tlast: end
//  m_axis  | out | digest_word[31:0]        | tuser: word_index, tlast: last
//
// Bytes are taken one per cycle while no finished block waits in the slot.
// Each block passes through the compression core as load, 64 rounds, fold;
// while a finished block waits for the core, the byte side stalls.
// End of message shifts in padding one byte per cycle (pausing while a full
// block waits in the slot) with the byte side stalled, then hands over the
// length block; eight output words follow once it is compressed.
// Reset is synchronous and restores the initial hash.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // has_byte
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // digest_word
  output logic [2:0]       m_axis_tuser,   // word_index
  output logic             m_axis_tlast    // last_word
);
  import sha256_pkg::*;

  blk_req_t    blk;
  logic        blk_valid, blk_ready;

  // Front end: byte packing and padding.
  sha256_front u_front (
    .clk, .rst, .data_byte(s_axis_tdata), .has_byte(s_axis_tuser),
    .end_of_message(s_axis_tlast), .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready), .blk, .blk_valid, .blk_ready);

  // Back end: compression and digest output.
  sha256_core u_core (
    .clk, .rst, .blk, .blk_valid, .blk_ready, .digest_word(m_axis_tdata),
    .word_index(m_axis_tuser), .last_word(m_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready));
endmodule
`default_nettype wire

// ----- rtl/sha256_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte front end
// Shifts message bytes into 512-bit blocks, shifts in the padding one byte per
// cycle unless a completed block must wait for the slot, appends the bit length
// and hands finished blocks to the compression core through a one-entry slot.
// ----------------------------------------------------------------------------
module sha256_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  has_byte,
  input  wire logic                  end_of_message,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output sha256_pkg::blk_req_t       blk,
  output logic                       blk_valid,
  input  wire logic                  blk_ready
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_BYTES = 3'b001,
    S_PAD   = 3'b010,
    S_LEN   = 3'b100
  } fstate_t;

  fstate_t      state;
  logic [511:0] buffer;
  logic [5:0]   fill;
  logic [63:0]  byte_count;
  logic         out_full;
  logic         pad_first;
  logic         push_ok;
  logic         accept;
  logic [511:0] shifted;
  logic [511:0] pad_shift;
  logic         pad_step;
  logic         push;
  logic [511:0] push_block;
  logic         push_final;

  // A block is handed over only when the output slot is free or draining.
  assign push_ok   = !out_full || blk_ready;
  assign in_ready  = (state == S_BYTES) && push_ok;
  assign blk_valid = out_full;
  assign accept    = in_valid && in_ready;

  // Bytes enter at the bottom, so byte 0 of a block ends up in the top bits.
  always_comb begin
    shifted    = {buffer[503:0], data_byte};
    pad_shift  = {buffer[503:0], (pad_first ? PadByte : 8'h00)};
    pad_step   = (state == S_PAD) && ((fill != 6'd63) || push_ok);
    push       = 1'b0;
    push_block = shifted;
    push_final = 1'b0;
    case (state)
      S_BYTES: push = accept && has_byte && (fill == 6'd63);
      S_PAD: begin
        push       = pad_step && (fill == 6'd63);
        push_block = pad_shift;
      end
      S_LEN: begin
        // The bit length wraps at 64 bits.
        push       = push_ok;
        push_block = {buffer[447:0], byte_count[60:0], 3'b000};
        push_final = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BYTES; fill <= '0; byte_count <= '0; out_full <= 1'b0;
      pad_first <= 1'b0;
    end else begin
      // Hand-over slot toward the core.
      if (push) begin
        blk.block <= push_block; blk.final_blk <= push_final; out_full <= 1'b1;
      end else if (blk_ready) begin
        out_full <= 1'b0;
      end
      case (state)
        S_BYTES: if (accept) begin
          if (has_byte) begin
            buffer <= shifted;
            fill <= fill + 6'd1;
          end
          byte_count <= byte_count + {63'd0, has_byte};
          if (end_of_message) begin
            pad_first <= 1'b1;
            state <= S_PAD;
          end
        end
        // The pad byte 0x80 goes first, then zeros up to the length field.
        S_PAD: if (pad_step) begin
          buffer <= pad_shift;
          fill <= fill + 6'd1;
          pad_first <= 1'b0;
          if (fill == 6'(LenOffset - 1)) state <= S_LEN;
        end
        S_LEN: if (push_ok) begin
          fill <= '0; byte_count <= '0;
          state <= S_BYTES;
        end
        default: state <= S_BYTES;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sha256_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds per block, one round per cycle, with a rolling 16-word
// schedule, and emits the eight digest words after a final block.
// ----------------------------------------------------------------------------
module sha256_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  sha256_pkg::blk_req_t    blk,
  input  wire logic               blk_valid,
  output logic                    blk_ready,
  output logic [31:0]             digest_word,
  output logic [2:0]              word_index,
  output logic                    last_word,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import sha256_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_ROUND = 4'b0010,
    C_FOLD  = 4'b0100,
    C_EMIT  = 4'b1000
  } cstate_t;

  cstate_t      state;
  logic [255:0] hash;
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [511:0] w;
  logic [5:0]   rnd;
  logic         final_blk;
  logic [2:0]   idx;
  logic [31:0]  wt, wn, t1, t2;

  assign blk_ready = (state == C_IDLE);

  // Window holds w[t..t+15]; w[t] is the top word.
  always_comb begin
    logic [31:0] w1, w14, w0, w9;
    w0  = w[511 -: 32];
    w1  = w[479 -: 32];
    w9  = w[223 -: 32];
    w14 = w[63 -: 32];
    wt = w0;
    wn = w0 + (rotr(w1,7) ^ rotr(w1,18) ^ (w1 >> 3)) + w9
       + (rotr(w14,17) ^ rotr(w14,19) ^ (w14 >> 10));
    t1 = h + (rotr(e,6) ^ rotr(e,11) ^ rotr(e,25)) + ((e & f) ^ (~e & g))
       + round_k(rnd) + wt;
    t2 = (rotr(a,2) ^ rotr(a,13) ^ rotr(a,22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  assign digest_word = hash[255 - 32*idx -: 32];
  assign word_index  = idx;
  assign last_word   = (idx == 3'd7);
  assign out_valid   = (state == C_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE; hash <= InitHash; rnd <= '0; idx <= '0;
    end else begin
      case (state)
        C_IDLE: if (blk_valid) begin
          w <= blk.block; final_blk <= blk.final_blk; rnd <= '0;
          {a, b, c, d, e, f, g, h} <= hash;
          state <= C_ROUND;
        end
        C_ROUND: begin
          h <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          w <= {w[479:0], wn};
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= C_FOLD;
        end
        C_FOLD: begin
          hash <= {hash[255:224] + a, hash[223:192] + b, hash[191:160] + c,
                   hash[159:128] + d, hash[127:96] + e, hash[95:64] + f,
                   hash[63:32] + g, hash[31:0] + h};
          idx <= '0;
          state <= final_blk ? C_EMIT : C_IDLE;
        end
        C_EMIT: if (out_ready) begin
          idx <= idx + 3'd1;
          if (idx == 3'd7) begin
            hash <= InitHash; state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sha256_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the output stream of the hasher over time.
// ----------------------------------------------------------------------------
module sha256_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);
  // The last flag marks exactly the eighth word.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("last flag off index 7");
  // Word index steps by one after each taken word within a digest.
  a_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest word index skipped");
  // A stalled word holds its index.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tuser))
    else $error("index changed under stall");
endmodule

bind sha256_message_hasher sha256_checker u_chk (.*);
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Feeds byte streams into the hasher, computes each digest with an in-bench
// SHA-256 model, and checks every digest word, index and last flag in order.
// ----------------------------------------------------------------------------
module tb;
  import sha256_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
  logic        s_axis_tuser = 1'b0;    // has_byte
  logic        s_axis_tlast = 1'b0;    // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // digest_word
  logic [2:0]  m_axis_tuser;           // word_index
  logic        m_axis_tlast;           // last_word

  sha256_message_hasher dut (.*);

  // Model state of the hasher.
  logic [31:0] model_hash[8];
  logic [7:0]  model_block[64];
  int unsigned model_fill;
  logic [63:0] model_len;
  logic [31:0] k_table[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  digest_word_t pending_words[$];
  int errors = 0;
  int requests_sent = 0;
  int messages_sent = 0;
  int words_seen = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int hold_asks = 0;
  int holds_served = 0;
  bit word_taken = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of the model block into the model hash.
  function automatic void compress_model_block();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {model_block[4*t], model_block[4*t+1], model_block[4*t+2], model_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-7]
             + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    {a, b, c, d} = {model_hash[0], model_hash[1], model_hash[2], model_hash[3]};
    {e, f, g, h} = {model_hash[4], model_hash[5], model_hash[6], model_hash[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + k_table[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    model_hash[0] += a; model_hash[1] += b; model_hash[2] += c; model_hash[3] += d;
    model_hash[4] += e; model_hash[5] += f; model_hash[6] += g; model_hash[7] += h;
  endfunction

  function automatic void restart_model();
    for (int i = 0; i < 8; i++) model_hash[i] = InitHash[255 - 32*i -: 32];
    model_fill = 0;
    model_len = '0;
  endfunction

  // Advance the model by one accepted request and queue any digest words.
  function automatic void hash_request(logic [7:0] data, logic has, logic eom);
    logic [63:0] bits;
    digest_word_t dw;
    if (has) begin
      model_block[model_fill] = data;
      model_fill = (model_fill + 1) % 64;
      model_len += 1;
      if (model_fill == 0) compress_model_block();
    end
    if (!eom) return;
    bits = model_len << 3;
    model_block[model_fill] = PadByte;
    for (int i = model_fill + 1; i < 64; i++) model_block[i] = 8'h00;
    if (model_fill >= LenOffset) begin
      compress_model_block();
      for (int i = 0; i < 56; i++) model_block[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) model_block[56 + i] = bits[63 - 8*i -: 8];
    compress_model_block();
    for (int i = 0; i < 8; i++) begin
      dw.word = model_hash[i];
      dw.index = 3'(i);
      dw.last = (i == 7);
      pending_words.push_back(dw);
    end
    restart_model();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s at word %0d: got %h, expected %h", what, words_seen, got, want);
    errors++;
  endtask

  // Send one request with a random lead-in gap; returns after the handshake.
  task automatic send_request(logic [7:0] data, logic has, logic eom);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = data;
    s_axis_tuser = has;
    s_axis_tlast = eom;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    hash_request(data, has, eom);
    requests_sent++;
    if (eom) messages_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit end_with_byte);
    for (int i = 0; i < len; i++)
      send_request(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
    if (!end_with_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stalls per word, plus long holds when asked.
  always @(negedge clk) begin
    static int stall = 0;
    static int hold = 0;
    if (hold_asks != holds_served) begin
      hold = 400;
      holds_served <= hold_asks;
    end
    if (word_taken) stall = calm ? 0 : $urandom_range(0, 5);
    if (hold > 0) begin
      hold--;
      m_axis_tready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Digest word checker.
  always @(posedge clk) begin
    digest_word_t want;
    word_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, '0);
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata !== want.word)
          report_mismatch("digest_word", m_axis_tdata, want.word);
        if (m_axis_tuser !== want.index)
          report_mismatch("word_index", 32'(m_axis_tuser), 32'(want.index));
        if (m_axis_tlast !== want.last)
          report_mismatch("last_word", 32'(m_axis_tlast), 32'(want.last));
      end
      words_seen++;
    end
  end

  // Empty message, short messages, idle requests, extreme byte values.
  task automatic test_directed();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h55, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'haa, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  // Lengths around the padding and block boundaries.
  task automatic test_block_boundaries();
    int lens[4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i], 1'(i % 2));
  endtask

  // Receiver holds off while several messages are offered.
  task automatic test_backpressure();
    hold_asks++;
    calm = 1'b1;
    for (int i = 0; i < 3; i++)
      send_message(int'($urandom_range(1, 20)), 1'($urandom_range(0, 1)));
    calm = 1'b0;
  endtask

  task automatic test_random_messages();
    int len;
    int pick;
    while (requests_sent < 340) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(0, 20);
      else len = $urandom_range(50, 70);
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_message(len, 1'($urandom_range(0, 1)));
    end
    calm = 1'b0;
  endtask

  initial begin
    restart_model();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_block_boundaries();
    test_backpressure();
    test_random_messages();
    s_axis_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d requests in %0d messages, %0d digest words checked.",
             requests_sent, messages_sent, words_seen);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/sha256_pkg.sv
rtl/sha256_front.sv
rtl/sha256_core.sv
rtl/sha256_message_hasher.sv
rtl/sha256_checker.sv
bench/tb.sv
